// ===== src/pct_pkg.sv =====
package pct_pkg;

  // Field and register widths
  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS  = 8;
  localparam int OP_W       = 3;
  localparam int DELTA_W    = 9;
  localparam int BTN_W      = 8;
  localparam int POS_W      = COORD_BITS + 1;
  localparam int SENS_W     = 8;
  localparam int NBTN       = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  // Derived datapath widths
  localparam int LOG_W     = COORD_BITS + FRAC_BITS;
  localparam int SCALE_W   = DELTA_W + SENS_W + FRAC_BITS;
  localparam int PROD_W    = 2 * COORD_BITS;
  localparam int DIV_W     = (SCALE_W > PROD_W) ? SCALE_W : PROD_W;
  localparam int SUM_W     = ((SCALE_W > LOG_W) ? SCALE_W : LOG_W) + 2;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int RESET_POS = 10;

  // Opcodes
  localparam logic [OP_W-1:0] OP_MOVE     = 3'd0;
  localparam logic [OP_W-1:0] OP_BTN_DOWN = 3'd1;
  localparam logic [OP_W-1:0] OP_BTN_UP   = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESCALE  = 3'd4;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_DISPLAY_PRESENT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DESK_WIDTH      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DESK_HEIGHT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SENS_NUM        = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SENS_DEN        = 3'd6;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_BTN_SET,
    CMD_BTN_CLR,
    CMD_START_SCALE,
    CMD_WB_SCALE,
    CMD_START_PROJ,
    CMD_WB_PROJ,
    CMD_CLAMP_POS,
    CMD_CLAMP_CUR,
    CMD_START_LOG,
    CMD_WB_LOG,
    CMD_RESULT
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCALE_GO,
    S_SCALE_WAIT,
    S_PROJ_GO,
    S_PROJ_WAIT,
    S_CLAMP_POS,
    S_CLAMP_CUR,
    S_LOG_GO,
    S_LOG_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t cmd;
    logic axis;   // 0: x, 1: y
  } ctl_t;

  typedef struct packed {
    logic frame_ok;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== src/pct_div.sv =====
module pct_div
  import pct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIV_W-1:0]      num,
  input  logic [COORD_BITS-1:0] den,
  output logic                  done,
  output logic [DIV_W-1:0]      quo
);

  logic                  busy;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dsr;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [COORD_BITS:0]   trial;
  logic                  fits;

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? COORD_BITS'(trial - {1'b0, dsr}) : trial[COORD_BITS-1:0];
    end
  end

endmodule

// ===== src/pct_ctrl.sv =====
module pct_ctrl
  import pct_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] opcode,
  input  stat_t           stat,
  output ctl_t            ctl
);

  state_t          state, state_next;
  logic [OP_W-1:0] op;
  logic            axis, axis_next;
  state_t          axis_entry;

  // first step of a position operation on one axis
  always_comb begin
    unique case (op)
      OP_MOVE:    axis_entry = S_SCALE_GO;
      OP_SET_POS: axis_entry = S_CLAMP_POS;
      default:    axis_entry = S_CLAMP_CUR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      op    <= OP_MOVE;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      if (state == S_IDLE && in_valid) begin
        op <= opcode;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        axis_next = 1'b0;
        if ((op == OP_MOVE || op == OP_SET_POS || op == OP_RESCALE) && stat.frame_ok) begin
          state_next = axis_entry;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SCALE_GO: state_next = S_SCALE_WAIT;
      S_SCALE_WAIT: begin
        if (stat.div_done) begin
          state_next = S_PROJ_GO;
        end
      end
      S_PROJ_GO: state_next = S_PROJ_WAIT;
      S_PROJ_WAIT: begin
        if (stat.div_done) begin
          if (!axis) begin
            axis_next  = 1'b1;
            state_next = axis_entry;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_CLAMP_POS: state_next = S_LOG_GO;
      S_CLAMP_CUR: state_next = S_LOG_GO;
      S_LOG_GO:    state_next = S_LOG_WAIT;
      S_LOG_WAIT: begin
        if (stat.div_done) begin
          if (op == OP_RESCALE) begin
            state_next = S_PROJ_GO;
          end else if (!axis) begin
            axis_next  = 1'b1;
            state_next = axis_entry;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    ctl.cmd  = CMD_NONE;
    ctl.axis = axis;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd = CMD_LATCH;
        end
      end
      S_DISPATCH: begin
        if (op == OP_BTN_DOWN) begin
          ctl.cmd = CMD_BTN_SET;
        end else if (op == OP_BTN_UP) begin
          ctl.cmd = CMD_BTN_CLR;
        end
      end
      S_SCALE_GO: ctl.cmd = CMD_START_SCALE;
      S_SCALE_WAIT: begin
        if (stat.div_done) begin
          ctl.cmd = CMD_WB_SCALE;
        end
      end
      S_PROJ_GO: ctl.cmd = CMD_START_PROJ;
      S_PROJ_WAIT: begin
        if (stat.div_done) begin
          ctl.cmd = CMD_WB_PROJ;
        end
      end
      S_CLAMP_POS: ctl.cmd = CMD_CLAMP_POS;
      S_CLAMP_CUR: ctl.cmd = CMD_CLAMP_CUR;
      S_LOG_GO:    ctl.cmd = CMD_START_LOG;
      S_LOG_WAIT: begin
        if (stat.div_done) begin
          ctl.cmd = CMD_WB_LOG;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          ctl.cmd = CMD_RESULT;
        end
      end
      default: ctl.cmd = CMD_NONE;
    endcase
  end

endmodule

// ===== src/pct_dp.sv =====
module pct_dp
  import pct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  output stat_t                  stat,
  input  logic                   cfg_valid,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [DELTA_W-1:0]     delta_x,
  input  logic [DELTA_W-1:0]     delta_y,
  input  logic [BTN_W-1:0]       button_num,
  input  logic [POS_W-1:0]       pos_x,
  input  logic [POS_W-1:0]       pos_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  cursor_x,
  output logic [COORD_BITS-1:0]  cursor_y,
  output logic [NBTN-1:0]        buttons
);

  // configuration
  logic                  display_present;
  logic [COORD_BITS-1:0] frame_width, frame_height, desk_width, desk_height;
  logic [SENS_W-1:0]     sens_num, sens_den;

  // pointer state
  logic [LOG_W-1:0]      lpos_x, lpos_y;
  logic [COORD_BITS-1:0] screen_x, screen_y;
  logic [NBTN-1:0]       button_bits;

  // latched item
  logic [DELTA_W-1:0]    dx, dy;
  logic [BTN_W-1:0]      btn;
  logic [POS_W-1:0]      px, py;
  logic                  neg;

  // per-axis selection
  logic [DELTA_W-1:0]    cur_delta, abs_delta;
  logic [POS_W-1:0]      cur_pos;
  logic [LOG_W-1:0]      cur_logical;
  logic [COORD_BITS-1:0] cur_screen, cur_frame, cur_desk, cur_space;
  logic [COORD_BITS-1:0] frame_m1, space_m1;
  logic                  degen;

  logic [SENS_W-1:0]     num_s, den_s;
  logic [DELTA_W+SENS_W-1:0] delta_gain;
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_num, div_quo;
  logic [COORD_BITS-1:0] div_den;

  logic [SUM_W-1:0]      sum;
  logic [LOG_W-1:0]      max_fix, logical_clamped;
  logic [COORD_BITS-1:0] proj_pix, pos_pix, cur_pix;
  logic                  btn_ok;
  logic [NBTN-1:0]       btn_mask;

  function automatic logic button_num_l_ok(input logic [BTN_W-1:0] b);
    return (b >= BTN_W'(1)) && (b <= BTN_W'(NBTN));
  endfunction

  always_comb begin
    cur_delta   = ctl.axis ? dy : dx;
    cur_pos     = ctl.axis ? py : px;
    cur_logical = ctl.axis ? lpos_y : lpos_x;
    cur_screen  = ctl.axis ? screen_y : screen_x;
    cur_frame   = ctl.axis ? frame_height : frame_width;
    cur_desk    = ctl.axis ? desk_height : desk_width;
    cur_space   = (cur_desk != '0) ? cur_desk : cur_frame;
    frame_m1    = cur_frame - 1'b1;
    space_m1    = cur_space - 1'b1;
    degen       = (cur_frame <= COORD_BITS'(1)) || (cur_space <= COORD_BITS'(1));
    abs_delta   = cur_delta[DELTA_W-1] ? (~cur_delta + 1'b1) : cur_delta;
    num_s       = (sens_num != '0) ? sens_num : SENS_W'(1);
    den_s       = (sens_den != '0) ? sens_den : SENS_W'(1);
    delta_gain  = (DELTA_W+SENS_W)'(abs_delta) * (DELTA_W+SENS_W)'(num_s);
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = space_m1;
    case (ctl.cmd)
      CMD_START_SCALE: begin
        div_start = 1'b1;
        div_num   = DIV_W'({delta_gain, {FRAC_BITS{1'b0}}});
        div_den   = COORD_BITS'(den_s);
      end
      CMD_START_PROJ: begin
        div_start = 1'b1;
        div_num   = DIV_W'(cur_logical[LOG_W-1:FRAC_BITS]) * DIV_W'(frame_m1);
        div_den   = space_m1;
      end
      CMD_START_LOG: begin
        div_start = 1'b1;
        div_num   = DIV_W'(cur_screen) * DIV_W'(space_m1);
        div_den   = frame_m1;
      end
      default: ;
    endcase
  end

  pct_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // scaled motion added to or subtracted from the position, clamped to the desktop space
  always_comb begin
    max_fix = {space_m1, {FRAC_BITS{1'b0}}};
    if (neg) begin
      sum = SUM_W'(cur_logical) - SUM_W'(div_quo[SCALE_W-1:0]);
    end else begin
      sum = SUM_W'(cur_logical) + SUM_W'(div_quo[SCALE_W-1:0]);
    end
    if (sum[SUM_W-1]) begin
      logical_clamped = '0;
    end else if (sum > SUM_W'(max_fix)) begin
      logical_clamped = max_fix;
    end else begin
      logical_clamped = sum[LOG_W-1:0];
    end
  end

  // pixel results
  always_comb begin
    if (degen) begin
      proj_pix = '0;
    end else if (div_quo > DIV_W'(frame_m1)) begin
      proj_pix = frame_m1;
    end else begin
      proj_pix = div_quo[COORD_BITS-1:0];
    end

    if (cur_pos[POS_W-1]) begin
      pos_pix = '0;
    end else if (cur_pos > POS_W'(frame_m1)) begin
      pos_pix = frame_m1;
    end else begin
      pos_pix = cur_pos[COORD_BITS-1:0];
    end

    cur_pix = (cur_screen > frame_m1) ? frame_m1 : cur_screen;

    btn_ok   = (button_num_l_ok(btn));
    btn_mask = btn_ok ? NBTN'(1 << (btn[1:0] - 2'd1)) : '0;
  end

  assign stat.frame_ok = display_present && (frame_width != '0) && (frame_height != '0);
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid && !out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_present <= 1'b0;
      frame_width     <= '0;
      frame_height    <= '0;
      desk_width      <= '0;
      desk_height     <= '0;
      sens_num        <= SENS_W'(1);
      sens_den        <= SENS_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DISPLAY_PRESENT: display_present <= cfg_data[0];
        REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data;
        REG_DESK_WIDTH:      desk_width      <= cfg_data;
        REG_DESK_HEIGHT:     desk_height     <= cfg_data;
        REG_SENS_NUM:        sens_num        <= cfg_data[SENS_W-1:0];
        REG_SENS_DEN:        sens_den        <= cfg_data[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_LATCH) begin
      dx  <= delta_x;
      dy  <= delta_y;
      btn <= button_num;
      px  <= pos_x;
      py  <= pos_y;
    end
    if (ctl.cmd == CMD_START_SCALE) begin
      neg <= cur_delta[DELTA_W-1];
    end
  end

  // pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      lpos_x      <= LOG_W'(RESET_POS) << FRAC_BITS;
      lpos_y      <= LOG_W'(RESET_POS) << FRAC_BITS;
      screen_x    <= COORD_BITS'(RESET_POS);
      screen_y    <= COORD_BITS'(RESET_POS);
      button_bits <= '0;
    end else begin
      case (ctl.cmd)
        CMD_BTN_SET: button_bits <= button_bits | btn_mask;
        CMD_BTN_CLR: button_bits <= button_bits & ~btn_mask;
        CMD_WB_SCALE: begin
          if (ctl.axis) lpos_y <= logical_clamped;
          else          lpos_x <= logical_clamped;
        end
        CMD_WB_PROJ: begin
          if (ctl.axis) screen_y <= proj_pix;
          else          screen_x <= proj_pix;
        end
        CMD_CLAMP_POS: begin
          if (ctl.axis) screen_y <= pos_pix;
          else          screen_x <= pos_pix;
        end
        CMD_CLAMP_CUR: begin
          if (ctl.axis) screen_y <= cur_pix;
          else          screen_x <= cur_pix;
        end
        CMD_WB_LOG: begin
          if (ctl.axis) begin
            lpos_y <= degen ? '0 : {div_quo[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
          end else begin
            lpos_x <= degen ? '0 : {div_quo[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.cmd == CMD_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_RESULT) begin
      cursor_x <= screen_x;
      cursor_y <= screen_y;
      buttons  <= button_bits;
    end
  end

endmodule

// ===== src/pointer_cursor_tracker_core.sv =====
// Pointer cursor tracker. Keeps a logical pointer position (8 fraction bits)
// over the desktop space, a screen cursor and three button bits, and returns
// one result beat (cursor_x, cursor_y, buttons) for every input beat. All
// divisions (sensitivity scaling and the logical/screen projections) go
// through one shared restoring divider that yields a quotient bit a cycle;
// each division has a start step, its shift steps and a write-back step,
// and that divider sets the rate. With a display and frame size configured,
// move runs four divisions, rescale four and set position two; button and
// unused opcodes run none. A new input beat is taken once the previous result
// sits in the output register, so a waiting result does not hold up the
// next item's work. Configuration writes are accepted every cycle and must
// be made only while the block is idle.
module pointer_cursor_tracker_core
  import pct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  // input beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       opcode,
  input  logic [DELTA_W-1:0]    delta_x,
  input  logic [DELTA_W-1:0]    delta_y,
  input  logic [BTN_W-1:0]      button_num,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,

  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] cursor_x,
  output logic [COORD_BITS-1:0] cursor_y,
  output logic [NBTN-1:0]       buttons
);

  ctl_t  ctl;
  stat_t stat;

  // registers are simple flops, always writable
  assign cfg_ready = 1'b1;

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .stat     (stat),
    .ctl      (ctl)
  );

  pct_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .button_num (button_num),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .buttons    (buttons)
  );

endmodule
